// ===== rtl/core/fdrq_pkg.sv =====
// ----------------------------------------------------------------------------
// fdrq_pkg
// Types and constants shared by the frame deferred release queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdrq_pkg;

  // Width of the frame latency register.
  localparam int LAT_W = 2;

  // Command codes of a request beat.
  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_DEFER    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE  = 2'd2;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] handle;
    logic [3:0]  release_kind;
    logic [15:0] context_tag;
  } req_t;

  typedef struct packed {
    logic [31:0] handle_res;
    logic [3:0]  release_kind_res;
    logic [15:0] context_tag_res;
    logic        immediate;
    logic        last;
  } res_t;

  // One stored bucket entry.
  typedef struct packed {
    logic [15:0] context_tag;
    logic [3:0]  release_kind;
    logic [31:0] handle;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic append;
    logic load_imm;
    logic advance;
    logic shutdown;
    logic rd;
    logic close;
    logic push;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic room;
    logic req_kind_nz;
    logic more;
    logic at_end;
    logic rd_kind_nz;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/frame_deferred_release_queue.sv =====
// ----------------------------------------------------------------------------
// frame_deferred_release_queue
// Start and stored defer beats finish in the idle state; an immediate release
// also passes the flush state. Advance and shutdown read and check each stored
// entry (one memory read port), close each drained bucket, end with the final
// flush and then take the next beat; output stalls can hold check and flush.
// Synchronous reset empties every bucket, selects bucket 0, sets the latency
// to 1 and leaves the block inactive; the bucket memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_deferred_release_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_LATENCY = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [fdrq_pkg::LAT_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  fdrq_pkg::req_t             req,
  output logic                       res_valid,
  input  logic                       res_stall,
  output fdrq_pkg::res_t             res
);

  // The controller walks each request through its phases: idle for start and
  // stored defers, a flush for immediate releases, a read/check loop over
  // bucket memory for advance and shutdown. Beats are only taken while idle.
  //
  // Results pass through a one-entry pending stage before the output register.
  // Because entries of release kind 0 produce nothing, the block cannot know
  // that a result is the final one until the drain has finished; holding each
  // result back by one lets the last flag be set correctly on the flush.

  fdrq_pkg::cmd_t    cmd;
  fdrq_pkg::status_t status;

  fdrq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .status      (status),
    .cmd         (cmd),
    .req_stall   (req_stall)
  );

  fdrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_LATENCY (MAX_LATENCY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

  // Whenever a request beat can be taken, nothing is left in the pending stage.
  a_idle_pend_empty : assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !status.pend_valid)
    else $error("pending result left over while accepting requests");

  // A result that is not the last one means the drain is still running.
  a_not_last_busy : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> req_stall)
    else $error("non-final result shown while the block is idle");

  // An accepted start leaves the block active.
  a_start_active : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.command == fdrq_pkg::CMD_START) |=> status.active)
    else $error("block not active after start");

  // An accepted shutdown leaves the block inactive.
  a_shutdown_inactive : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.command == fdrq_pkg::CMD_SHUTDOWN) |=> !status.active)
    else $error("block still active after shutdown");

endmodule

// ===== rtl/core/fdrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdrq_ctrl
// Controller that sequences request beats, bucket drains and the final flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdrq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_command,
  input  fdrq_pkg::status_t  status,
  output fdrq_pkg::cmd_t     cmd,
  output logic               req_stall
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_command)
            fdrq_pkg::CMD_START: begin
              cmd.start = 1'b1;
            end
            fdrq_pkg::CMD_DEFER: begin
              if (status.active && status.room) begin
                cmd.append = 1'b1;
              end else if (status.req_kind_nz) begin
                cmd.load_imm = 1'b1;
                state_next   = S_FLUSH;
              end
            end
            fdrq_pkg::CMD_ADVANCE: begin
              if (status.active) begin
                cmd.advance = 1'b1;
                state_next  = S_READ;
              end
            end
            fdrq_pkg::CMD_SHUTDOWN: begin
              if (status.active) begin
                cmd.shutdown = 1'b1;
                state_next   = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (status.more) begin
          cmd.rd     = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.close = 1'b1;
          if (status.at_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_CHECK: begin
        if (!status.rd_kind_nz) begin
          state_next = S_READ;
        end else if (!status.pend_valid || status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_READ;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

// ===== rtl/core/fdrq_datapath.sv =====
// ----------------------------------------------------------------------------
// fdrq_datapath
// Bucket memory, bucket counts, ring index and the pending and output stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdrq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_LATENCY = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fdrq_pkg::LAT_W-1:0]   cfg_data,
  input  fdrq_pkg::req_t               req,
  input  fdrq_pkg::cmd_t               cmd,
  output fdrq_pkg::status_t            status,
  input  logic                         res_stall,
  output logic                         res_valid,
  output fdrq_pkg::res_t               res
);

  localparam int DEPTH = MAX_LATENCY * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (MAX_LATENCY > 1) ? $clog2(MAX_LATENCY) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LW    = fdrq_pkg::LAT_W;

  localparam logic [AW-1:0] QD     = AW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] QCNT   = CW'(QUEUE_DEPTH);
  localparam logic [BW-1:0] LAST_B = BW'(MAX_LATENCY - 1);

  fdrq_pkg::entry_t mem [DEPTH];
  fdrq_pkg::entry_t rdata;

  logic [CW-1:0] counts [MAX_LATENCY];
  logic [BW-1:0] bucket;
  logic [BW-1:0] end_bucket;
  logic [CW-1:0] idx;
  logic [LW-1:0] latency;
  logic [LW-1:0] latency_next;
  logic          active;
  logic          pend_valid;
  logic          out_valid;
  fdrq_pkg::res_t pend;
  fdrq_pkg::res_t out;

  logic [CW-1:0] cur_count;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] bucket_adv;
  logic          out_free;

  // Step the ring index modulo the latency by repeated subtraction; the
  // incremented index never exceeds MAX_LATENCY.
  function automatic logic [BW-1:0] next_bucket(input logic [BW-1:0] b,
                                                 input logic [LW-1:0] lat);
    logic [BW:0] v;
    logic [BW:0] l;
    v = {1'b0, b} + (BW + 1)'(1);
    l = (BW + 1)'(lat);
    for (int k = 0; k < MAX_LATENCY; k++) begin
      if (v >= l) begin
        v = v - l;
      end
    end
    return v[BW-1:0];
  endfunction

  always_comb begin
    if (cfg_data == '0) begin
      latency_next = LW'(1);
    end else if (int'(cfg_data) > MAX_LATENCY) begin
      latency_next = LW'(MAX_LATENCY);
    end else begin
      latency_next = cfg_data;
    end
  end

  assign cur_count  = counts[bucket];
  assign wr_addr    = AW'(bucket) * QD + AW'(cur_count);
  assign rd_addr    = AW'(bucket) * QD + AW'(idx);
  assign bucket_adv = next_bucket(bucket, latency);
  assign out_free   = !out_valid || !res_stall;

  // Bucket memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= '{context_tag:  req.context_tag,
                        release_kind: req.release_kind,
                        handle:       req.handle};
    end
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      bucket     <= '0;
      latency    <= LW'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_LATENCY; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        latency <= latency_next;
      end
      if (cmd.start) begin
        for (int i = 0; i < MAX_LATENCY; i++) begin
          counts[i] <= '0;
        end
        bucket <= '0;
        active <= 1'b1;
      end
      if (cmd.append) begin
        counts[bucket] <= cur_count + CW'(1);
      end
      if (cmd.advance) begin
        bucket <= bucket_adv;
      end
      if (cmd.shutdown) begin
        bucket <= '0;
        active <= 1'b0;
      end
      if (cmd.close) begin
        counts[bucket] <= '0;
        if (!status.at_end) begin
          bucket <= bucket + BW'(1);
        end
      end
      // A new result may replace the one taken in the same cycle.
      if ((cmd.push && pend_valid) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_imm || cmd.push) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      end_bucket <= bucket_adv;
      idx        <= '0;
    end
    if (cmd.shutdown) begin
      end_bucket <= LAST_B;
      idx        <= '0;
    end
    if (cmd.rd) begin
      idx <= idx + CW'(1);
    end
    if (cmd.close) begin
      idx <= '0;
    end
    if (cmd.load_imm) begin
      pend <= '{handle_res:       req.handle,
                release_kind_res: req.release_kind,
                context_tag_res:  req.context_tag,
                immediate:        1'b1,
                last:             1'b0};
    end
    if (cmd.push) begin
      pend <= '{handle_res:       rdata.handle,
                release_kind_res: rdata.release_kind,
                context_tag_res:  rdata.context_tag,
                immediate:        1'b0,
                last:             1'b0};
      if (pend_valid) begin
        out <= pend;
      end
    end
    if (cmd.finish) begin
      out <= '{handle_res:       pend.handle_res,
               release_kind_res: pend.release_kind_res,
               context_tag_res:  pend.context_tag_res,
               immediate:        pend.immediate,
               last:             1'b1};
    end
  end

  assign status.active      = active;
  assign status.room        = (cur_count < QCNT);
  assign status.req_kind_nz = (req.release_kind != 4'd0);
  assign status.more        = (idx < cur_count);
  assign status.at_end      = (bucket == end_bucket);
  assign status.rd_kind_nz  = (rdata.release_kind != 4'd0);
  assign status.pend_valid  = pend_valid;
  assign status.out_free    = out_free;

  assign res_valid = out_valid;
  assign res       = out;

endmodule
